// File: rtl/core/assert_macros.svh
// assertion macros shared by the timer pool rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MCTP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define MCTP_ASSERT_NEVER(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error(msg);

`endif

// File: rtl/core/mctp_pkg.sv
// types and constants of the millisecond timer pool
`timescale 1ns / 1ps
`default_nettype none

package mctp_pkg;

  // command codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ALLOC      = 3'd1;
  localparam logic [2:0] OP_FREE       = 3'd2;
  localparam logic [2:0] OP_START      = 3'd3;
  localparam logic [2:0] OP_STOP       = 3'd4;
  localparam logic [2:0] OP_RESTART    = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;
  localparam logic [2:0] OP_READ_TICKS = 3'd7;

  // result kinds
  localparam logic [2:0] K_ACK    = 3'd0;
  localparam logic [2:0] K_ALLOC  = 3'd1;
  localparam logic [2:0] K_NONE   = 3'd2;
  localparam logic [2:0] K_STATUS = 3'd3;
  localparam logic [2:0] K_EVENT  = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;

  // timer modes
  localparam logic [1:0] M_ONESHOT = 2'd0;
  localparam logic [1:0] M_REPEAT  = 2'd1;

  // step register
  localparam int         STEP_W            = 10;
  localparam logic [9:0] MS_PER_TICK_RESET = 10'd10;

  // event cap per tick
  localparam int MAX_RESULTS = 8;
  localparam int EVW         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_FIND,
    ST_LOAD,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic        is_expired;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/mctp_ram.sv
// single write port, single registered read port count memory
`timescale 1ns / 1ps
`default_nettype none

module mctp_ram
  import mctp_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int WIDTH = 24,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/mctp_count_unit.sv
// shared count step unit: subtract with floor, expiry detect and reload
`timescale 1ns / 1ps
`default_nettype none

module mctp_count_unit
  import mctp_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic [COUNT_WIDTH-1:0] rem,
  input  wire logic [COUNT_WIDTH-1:0] rld,
  input  wire logic [STEP_W-1:0]      step,
  input  wire logic                   reload,
  output logic      [COUNT_WIDTH-1:0] rem_next,
  output logic                        expired
);

  localparam int CEW = (COUNT_WIDTH > STEP_W) ? COUNT_WIDTH : STEP_W;

  logic [CEW-1:0] rem_e;
  logic [CEW-1:0] step_e;
  logic [CEW-1:0] diff;
  logic           dec;

  // compare and subtract in a width that holds both operands
  assign rem_e  = CEW'(rem);
  assign step_e = CEW'(step);
  assign diff   = rem_e - step_e;
  assign dec    = (rem != '0) && (rem_e > step_e);

  // floor at zero, reload a repeating timer
  always_comb begin
    if (dec) begin
      rem_next = COUNT_WIDTH'(diff);
    end else if (reload) begin
      rem_next = rld;
    end else begin
      rem_next = '0;
    end
  end

  assign expired = !dec;

endmodule

`default_nettype wire

// File: rtl/core/multi_channel_ms_timer_pool.sv
// top level of the millisecond timer pool: sequencer, slot flags and results
// tick: busy while it walks the slots, one slot per cycle through the count unit, then a flush
// allocate: busy while it searches, one slot per cycle from the top
// start and query of an allocated slot: busy for the count memory read; other commands: not busy
// each result is a one-cycle strobe on result_valid, the last one registered as the work ends
// rst is synchronous: all slots free and stopped, tick counter zero, ms_per_tick 10
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multi_channel_ms_timer_pool
  import mctp_pkg::*;
#(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op,
  input  wire logic [2:0]  timer_id,
  input  wire logic [1:0]  timer_mode,
  input  wire logic        start_now,
  input  wire logic        notify,
  input  wire logic [23:0] duration_ms,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data,
  output logic             result_valid,
  output logic [2:0]       kind,
  output logic [2:0]       slot,
  output logic             is_expired,
  output logic [31:0]      value,
  output logic             last
);

  localparam int             SW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [SW-1:0]  TOP = SW'(NUM_TIMERS - 1);

  state_t state;
  state_t state_next;

  logic [STEP_W-1:0]      ms_per_tick;
  logic [31:0]            tick_total;
  logic [NUM_TIMERS-1:0]  in_use;
  logic [NUM_TIMERS-1:0]  running;
  logic [NUM_TIMERS-1:0]  notify_q;
  logic [1:0]             mode_q [NUM_TIMERS];

  logic [SW-1:0]          idx;
  logic [SW-1:0]          cmd_id;
  logic [1:0]             cmd_mode;
  logic                   cmd_start_now;
  logic                   cmd_notify;
  logic [COUNT_WIDTH-1:0] cmd_dur;

  logic                   pend_valid;
  logic [2:0]             pend_slot;
  logic [EVW-1:0]         ev_count;
  result_t                res;

  logic [SW-1:0]          id_idx;
  logic                   id_ok;
  logic [COUNT_WIDTH-1:0] dur_cnt;
  logic                   active;

  logic [SW-1:0]          rd_addr;
  logic [SW-1:0]          waddr;
  logic                   rem_we;
  logic                   rld_we;
  logic [COUNT_WIDTH-1:0] rem_wdata;
  logic [COUNT_WIDTH-1:0] rd_rem;
  logic [COUNT_WIDTH-1:0] rd_rld;
  logic [COUNT_WIDTH-1:0] cu_rem_next;
  logic                   cu_expired;

  // command decode helpers
  assign id_idx  = SW'(timer_id);
  assign id_ok   = (int'(timer_id) < NUM_TIMERS) && in_use[id_idx];
  assign dur_cnt = COUNT_WIDTH'(duration_ms);
  assign active  = in_use[idx] && running[idx];

  // count and reload memories
  mctp_ram #(.DEPTH(NUM_TIMERS), .WIDTH(COUNT_WIDTH), .AW(SW)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (waddr),
    .wdata (rem_wdata),
    .raddr (rd_addr),
    .rdata (rd_rem)
  );

  mctp_ram #(.DEPTH(NUM_TIMERS), .WIDTH(COUNT_WIDTH), .AW(SW)) u_rld_ram (
    .clk   (clk),
    .we    (rld_we),
    .waddr (waddr),
    .wdata (rem_wdata),
    .raddr (rd_addr),
    .rdata (rd_rld)
  );

  // shared count step unit
  mctp_count_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
    .rem      (rd_rem),
    .rld      (rd_rld),
    .step     (ms_per_tick),
    .reload   (mode_q[idx] == M_REPEAT),
    .rem_next (cu_rem_next),
    .expired  (cu_expired)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_TICK:  state_next = ST_WALK;
            OP_ALLOC: state_next = ST_FIND;
            OP_START: state_next = id_ok ? ST_LOAD : ST_IDLE;
            OP_QUERY: state_next = id_ok ? ST_QUERY : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (idx == '0) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FIND: begin
        if (!in_use[idx] || idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH, ST_LOAD, ST_QUERY: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr   = idx;
    waddr     = idx;
    rem_we    = 1'b0;
    rld_we    = 1'b0;
    rem_wdata = dur_cnt;
    case (state)
      ST_IDLE: begin
        rd_addr = (op == OP_TICK) ? TOP : id_idx;
        waddr   = id_idx;
        if (start && op == OP_RESTART && id_ok) begin
          rem_we = 1'b1;
          rld_we = 1'b1;
        end
      end
      ST_WALK: begin
        rd_addr   = SW'(idx - 1'b1);
        rem_we    = active;
        rem_wdata = cu_rem_next;
      end
      ST_FIND: begin
        rem_wdata = cmd_dur;
        rem_we    = !in_use[idx];
        rld_we    = !in_use[idx];
      end
      ST_LOAD: begin
        waddr     = cmd_id;
        rem_we    = 1'b1;
        rem_wdata = rd_rld;
      end
      default: begin
        rd_addr = cmd_id;
      end
    endcase
  end

  // command capture, flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ms_per_tick  <= MS_PER_TICK_RESET;
      tick_total   <= '0;
      in_use       <= '0;
      running      <= '0;
      notify_q     <= '0;
      mode_q       <= '{default: M_ONESHOT};
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      ev_count     <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid) begin
        ms_per_tick <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_id        <= id_idx;
            cmd_mode      <= timer_mode;
            cmd_start_now <= start_now;
            cmd_notify    <= notify;
            cmd_dur       <= dur_cnt;
            case (op)
              OP_TICK: begin
                tick_total <= tick_total + 32'd1;
                idx        <= TOP;
                ev_count   <= '0;
                pend_valid <= 1'b0;
              end
              OP_ALLOC: begin
                idx <= TOP;
              end
              OP_READ_TICKS: begin
                result_valid <= 1'b1;
                res          <= '{K_STATUS, 3'd0, 1'b0, tick_total, 1'b1};
              end
              default: begin
                if (!id_ok) begin
                  result_valid <= 1'b1;
                  res          <= '{K_ERROR, timer_id, 1'b0, 32'd0, 1'b1};
                end else begin
                  case (op)
                    OP_FREE: begin
                      in_use[id_idx]   <= 1'b0;
                      running[id_idx]  <= 1'b0;
                      notify_q[id_idx] <= 1'b0;
                      mode_q[id_idx]   <= M_ONESHOT;
                      result_valid     <= 1'b1;
                      res              <= '{K_ACK, timer_id, 1'b0, 32'd0, 1'b1};
                    end
                    OP_STOP: begin
                      running[id_idx] <= 1'b0;
                      result_valid    <= 1'b1;
                      res             <= '{K_ACK, timer_id, 1'b0, 32'd0, 1'b1};
                    end
                    OP_RESTART: begin
                      running[id_idx] <= 1'b1;
                      result_valid    <= 1'b1;
                      res             <= '{K_ACK, timer_id, 1'b0, 32'd0, 1'b1};
                    end
                    default: begin
                    end
                  endcase
                end
              end
            endcase
          end
        end
        // one slot per cycle, highest first
        ST_WALK: begin
          idx <= SW'(idx - 1'b1);
          if (active && cu_expired) begin
            if (mode_q[idx] == M_ONESHOT) begin
              in_use[idx]   <= 1'b0;
              running[idx]  <= 1'b0;
              notify_q[idx] <= 1'b0;
            end
            if ((mode_q[idx] == M_ONESHOT || mode_q[idx] == M_REPEAT) &&
                notify_q[idx] && ev_count < EVW'(MAX_RESULTS)) begin
              if (pend_valid) begin
                result_valid <= 1'b1;
                res          <= '{K_EVENT, pend_slot, 1'b0, 32'd0, 1'b0};
              end
              pend_valid <= 1'b1;
              pend_slot  <= 3'(idx);
              ev_count   <= ev_count + 1'b1;
            end
          end
        end
        // held event closes the tick, or a plain ack
        ST_FLUSH: begin
          result_valid <= 1'b1;
          if (pend_valid) begin
            res <= '{K_EVENT, pend_slot, 1'b0, 32'd0, 1'b1};
          end else begin
            res <= '{K_ACK, 3'd0, 1'b0, 32'd0, 1'b1};
          end
          pend_valid <= 1'b0;
        end
        // highest free slot search
        ST_FIND: begin
          if (!in_use[idx]) begin
            in_use[idx]   <= 1'b1;
            running[idx]  <= cmd_start_now;
            notify_q[idx] <= cmd_notify;
            mode_q[idx]   <= cmd_mode;
            result_valid  <= 1'b1;
            res           <= '{K_ALLOC, 3'(idx), 1'b0, 32'd0, 1'b1};
          end else if (idx == '0) begin
            result_valid <= 1'b1;
            res          <= '{K_NONE, 3'd0, 1'b0, 32'd0, 1'b1};
          end else begin
            idx <= SW'(idx - 1'b1);
          end
        end
        ST_LOAD: begin
          running[cmd_id] <= 1'b1;
          result_valid    <= 1'b1;
          res             <= '{K_ACK, 3'(cmd_id), 1'b0, 32'd0, 1'b1};
        end
        ST_QUERY: begin
          result_valid <= 1'b1;
          res          <= '{K_STATUS, 3'(cmd_id), running[cmd_id] && (rd_rem == '0),
                            32'(rd_rem), 1'b1};
        end
        default: begin
        end
      endcase
    end
  end

  // port drive
  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign kind       = res.kind;
  assign slot       = res.slot;
  assign is_expired = res.is_expired;
  assign value      = res.value;
  assign last       = res.last;

  // checks
  `MCTP_ASSERT_NEVER(a_ev_cap, clk, rst, ev_count > EVW'(MAX_RESULTS), "event cap exceeded")
  `MCTP_ASSERT(a_pend_count, clk, rst, pend_valid |-> ev_count != '0, "held event not counted")
  `MCTP_ASSERT(a_walk_ticks, clk, rst, state == ST_WALK |=> $stable(tick_total), "ticks moved")
  `MCTP_ASSERT(a_res_cause, clk, rst, result_valid |-> $past(busy || start), "stray result")

endmodule

`default_nettype wire
